// ===== rtl/roof_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roof_pkg: shared types and constants for the read overlap orientation finder
// Holds the store geometry, payload structs, the controller/datapath command
// and status structs, the controller state encoding and the complement table.
// ----------------------------------------------------------------------------
package roof_pkg;

   localparam int MAX_LEN    = 256;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int PERMILLE_W = 10;
   localparam int LIM_W      = LEN_W + PERMILLE_W;

   localparam logic [PERMILLE_W-1:0] PERMILLE_RESET = PERMILLE_W'(50);
   localparam logic [LIM_W-1:0]      ROUND_BIAS     = LIM_W'(499);
   localparam logic [LIM_W-1:0]      PERMILLE_DEN   = LIM_W'(1000);

   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_T_LO = 8'h74;

   typedef enum logic [2:0] {
      ORIENT_NONE = 3'd0,
      ORIENT_FF   = 3'd1,
      ORIENT_FR   = 3'd2,
      ORIENT_RF   = 3'd3,
      ORIENT_RR   = 3'd4
   } orient_type;

   localparam logic signed [7:0] SHIFT_NONE = -8'sd1;

   typedef struct packed {
      logic [7:0] base_char;
      logic       last_base;
   } req_payload_type;

   typedef struct packed {
      orient_type        orientation;
      logic signed [7:0] overlap_shift;
      logic              truncated;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SETUP,
      ST_BOUND,
      ST_SCAN,
      ST_DRAIN,
      ST_JUDGE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic wr_beat;
      logic start;
      logic setup;
      logic bound;
      logic issue;
      logic judge;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic prev_ok;
      logic scan_end;
      logic hit;
      logic shift_last;
   } dp_status_type;

   function automatic logic [7:0] comp_base(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_A_UP: r = CHAR_T_UP;
         CHAR_T_UP: r = CHAR_A_UP;
         CHAR_C_UP: r = CHAR_G_UP;
         CHAR_G_UP: r = CHAR_C_UP;
         CHAR_A_LO: r = CHAR_T_LO;
         CHAR_T_LO: r = CHAR_A_LO;
         CHAR_C_LO: r = CHAR_G_LO;
         CHAR_G_LO: r = CHAR_C_LO;
         default:   r = c;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/roof_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roof_dp: datapath of the read overlap orientation finder
// Two read banks with two read ports each, shift and position counters,
// four mismatch counters, the rounded bound and the result registers.
// ----------------------------------------------------------------------------
module roof_dp import roof_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [PERMILLE_W-1:0] csr_write_data,
   input  logic [7:0]            base_char,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output rsp_payload_type       rsp_data
);

   logic [PERMILLE_W-1:0] permille_ff, permille_in;
   logic [LEN_W-1:0]      cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]      prev_len_ff, prev_len_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic                  bank_ff, bank_in;
   logic                  ovf_ff, ovf_in;
   logic [ADDR_W-1:0]     shift_ff, shift_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   logic [LEN_W-1:0]      ol_ff, ol_in;
   logic [LIM_W-1:0]      lim_ff, lim_in;
   logic [LEN_W-1:0]      cnt_ff [4];
   logic [LEN_W-1:0]      cnt_in [4];
   logic                  rd_valid_ff, rd_valid_in;
   orient_type            res_orient_ff, res_orient_in;
   logic signed [7:0]     res_shift_ff, res_shift_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [7:0] mem_a [MAX_LEN];
   logic [7:0] mem_b [MAX_LEN];
   logic [7:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   logic [LEN_W-1:0]  prev_fwd, prev_rev, cur_fwd, cur_rev, rem_len, half_len;
   logic [ADDR_W-1:0] addr_a0, addr_a1, addr_b0, addr_b1;
   logic [7:0]        f1, r1, f2, r2;
   logic [3:0]        mism;
   logic [3:0]        in_bound;
   orient_type        judged;
   logic              room;

   // Addresses: previous read at d+j and its mirror, current read at j and its mirror
   always_comb begin
      prev_fwd = LEN_W'(shift_ff) + pos_ff;
      prev_rev = prev_len_ff - LEN_W'(1) - prev_fwd;
      cur_fwd  = pos_ff;
      cur_rev  = cur_len_ff - LEN_W'(1) - pos_ff;
      if (bank_ff) begin
         addr_a0 = prev_fwd[ADDR_W-1:0];
         addr_a1 = prev_rev[ADDR_W-1:0];
         addr_b0 = cur_fwd[ADDR_W-1:0];
         addr_b1 = cur_rev[ADDR_W-1:0];
      end else begin
         addr_a0 = cur_fwd[ADDR_W-1:0];
         addr_a1 = cur_rev[ADDR_W-1:0];
         addr_b0 = prev_fwd[ADDR_W-1:0];
         addr_b1 = prev_rev[ADDR_W-1:0];
      end
   end

   assign room = (cur_len_ff < LEN_W'(MAX_LEN));

   always_ff @(posedge clock) begin
      if (cmd.wr_beat && room && !bank_ff) begin
         mem_a[cur_len_ff[ADDR_W-1:0]] <= base_char;
      end
      if (cmd.wr_beat && room && bank_ff) begin
         mem_b[cur_len_ff[ADDR_W-1:0]] <= base_char;
      end
      rd_a0_ff <= mem_a[addr_a0];
      rd_a1_ff <= mem_a[addr_a1];
      rd_b0_ff <= mem_b[addr_b0];
      rd_b1_ff <= mem_b[addr_b1];
   end

   always_comb begin
      f1 = bank_ff ? rd_a0_ff : rd_b0_ff;
      r1 = comp_base(bank_ff ? rd_a1_ff : rd_b1_ff);
      f2 = bank_ff ? rd_b0_ff : rd_a0_ff;
      r2 = comp_base(bank_ff ? rd_b1_ff : rd_a1_ff);
      mism[0] = (f1 != f2);
      mism[1] = (f1 != r2);
      mism[2] = (r1 != f2);
      mism[3] = (r1 != r2);
   end

   // count <= floor(lim / 1000) is the same test as count * 1000 <= lim
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         in_bound[k] = ((LIM_W'(cnt_ff[k]) * PERMILLE_DEN) <= lim_ff);
      end
      if (in_bound[0]) begin
         judged = ORIENT_FF;
      end else if (in_bound[1]) begin
         judged = ORIENT_FR;
      end else if (in_bound[2]) begin
         judged = ORIENT_RF;
      end else if (in_bound[3]) begin
         judged = ORIENT_RR;
      end else begin
         judged = ORIENT_NONE;
      end
   end

   always_comb begin
      half_len          = prev_len_ff >> 1;
      rem_len           = prev_len_ff - LEN_W'(shift_ff);
      status.prev_ok    = prev_valid_ff && (half_len != '0);
      status.scan_end   = (pos_ff == (ol_ff - LEN_W'(1)));
      status.hit        = (in_bound != 4'b0000);
      status.shift_last = ((LEN_W'(shift_ff) + LEN_W'(1)) == half_len);
   end

   always_comb begin
      permille_in   = permille_ff;
      cur_len_in    = cur_len_ff;
      prev_len_in   = prev_len_ff;
      prev_valid_in = prev_valid_ff;
      bank_in       = bank_ff;
      ovf_in        = ovf_ff;
      shift_in      = shift_ff;
      pos_in        = pos_ff;
      ol_in         = ol_ff;
      lim_in        = lim_ff;
      rd_valid_in   = cmd.issue;
      res_orient_in = res_orient_ff;
      res_shift_in  = res_shift_ff;
      rsp_data_in   = rsp_data_ff;
      for (int k = 0; k < 4; k++) begin
         cnt_in[k] = cnt_ff[k];
      end

      if (csr_write_enable) begin
         permille_in = csr_write_data;
      end

      // Store the beat, or drop it and flag the read once the bank is full
      if (cmd.wr_beat) begin
         if (room) begin
            cur_len_in = cur_len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.start) begin
         shift_in      = '0;
         res_orient_in = ORIENT_NONE;
         res_shift_in  = SHIFT_NONE;
      end

      if (cmd.setup) begin
         pos_in = '0;
         ol_in  = (rem_len < cur_len_ff) ? rem_len : cur_len_ff;
         for (int k = 0; k < 4; k++) begin
            cnt_in[k] = '0;
         end
      end

      if (cmd.bound) begin
         lim_in = (LIM_W'(ol_ff) * LIM_W'(permille_ff)) + ROUND_BIAS;
      end

      if (cmd.issue) begin
         pos_in = pos_ff + LEN_W'(1);
      end

      if (rd_valid_ff) begin
         for (int k = 0; k < 4; k++) begin
            cnt_in[k] = cnt_ff[k] + LEN_W'(mism[k]);
         end
      end

      if (cmd.judge) begin
         shift_in = shift_ff + ADDR_W'(1);
         if (status.hit) begin
            res_orient_in = judged;
            res_shift_in  = 8'(shift_ff);
         end
      end

      // Close the read: it becomes the previous read and the banks swap
      if (cmd.commit) begin
         rsp_data_in.orientation   = res_orient_ff;
         rsp_data_in.overlap_shift = res_shift_ff;
         rsp_data_in.truncated     = ovf_ff;
         prev_len_in               = cur_len_ff;
         prev_valid_in             = 1'b1;
         bank_in                   = ~bank_ff;
         cur_len_in                = '0;
         ovf_in                    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         permille_ff   <= PERMILLE_RESET;
         cur_len_ff    <= '0;
         prev_len_ff   <= '0;
         prev_valid_ff <= 1'b0;
         bank_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         permille_ff   <= permille_in;
         cur_len_ff    <= cur_len_in;
         prev_len_ff   <= prev_len_in;
         prev_valid_ff <= prev_valid_in;
         bank_ff       <= bank_in;
         ovf_ff        <= ovf_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      pos_ff        <= pos_in;
      ol_ff         <= ol_in;
      lim_ff        <= lim_in;
      res_orient_ff <= res_orient_in;
      res_shift_ff  <= res_shift_in;
      rsp_data_ff   <= rsp_data_in;
      for (int k = 0; k < 4; k++) begin
         cnt_ff[k] <= cnt_in[k];
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/roof_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roof_ctrl: controller of the read overlap orientation finder
// Sequences storing beats, the shift loop, the scan of one overlap and the
// hand-off of the result into the output register.
// ----------------------------------------------------------------------------
module roof_ctrl import roof_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_stall,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.wr_beat = 1'b1;
               if (req_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = status.prev_ok ? ST_SETUP : ST_FINISH;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.bound = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = (status.hit || status.shift_last) ? ST_FINISH : ST_SETUP;
         end
         ST_FINISH: begin
            // Hold until the output register is free or drains this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/read_overlap_orientation_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// read_overlap_orientation_finder: overlap and orientation of successive reads
// Compares each closed read against the one before it, in four orientations.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one base per beat; last_base closes the
//   read. rsp_valid/rsp_stall/rsp_data carry one result per closed read:
//   orientation (none, FF, FR, RF, RR), the winning shift or -1, and the
//   truncated flag when more than MAX_LEN bases arrived (extras are dropped).
//   csr_write_enable/csr_write_data set mismatch_permille (reset value 50);
//   write it only while the block is idle.
// Timing:
//   A beat that does not close a read never stalls the input, so bases stream
//   at one per cycle. A closing beat stalls the input through a start step
//   and, for each tried shift d, the overlap length, the rounded bound, a
//   scan of the overlapping positions (both banks read at two ports each, all
//   four orientations counted at once), a drain of the read stage and the
//   judgement, then a finish step. The first read after reset or a previous
//   read shorter than two bases skips the shift loop and reports no match.
//   The result waits in the output register while rsp_stall is high; bases
//   of the next read are still taken, but the comparison for the next closing
//   beat holds in its final cycle until the waiting result has left.
// Reset clears lengths, bank select and the output valid; read banks are not
// cleared, since only written entries are ever compared.
// ----------------------------------------------------------------------------
module read_overlap_orientation_finder import roof_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write_enable,
   input  logic [PERMILLE_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Controller: state machine that steps the shift loop and the scan
   roof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_base),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: read banks, counters, bound and result registers
   roof_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .base_char        (req_data.base_char),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/roof_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roof_chk: port-level checks for the read overlap orientation finder
// Watches both channels and flags ordering and result encoding slips.
// ----------------------------------------------------------------------------
module roof_chk import roof_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // A waiting result holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // No match always reports shift -1
   a_none_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.orientation == ORIENT_NONE) |->
         (rsp_data.overlap_shift == SHIFT_NONE))
      else $error("no-match result with a shift");

   // The input stalls only after a closing beat was taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall && req_data.last_base))
      else $error("input stalled without a closing beat");

   // A new result appears only at the end of a busy period
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall) && !req_stall)
      else $error("result appeared outside the end of a comparison");

endmodule

bind read_overlap_orientation_finder roof_chk u_roof_chk (.*);
`default_nettype wire

// ===== tb/tb_read_overlap_orientation_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_read_overlap_orientation_finder: self-checking bench for the overlap finder
// Streams reads one base per beat and keeps a local model of both read banks.
// At each closing beat it scores the closed read against the one before it and
// queues the verdict. Each response beat is then checked field by field. The
// run starts with hand-made reads and then moves to random reads, most of them
// cut from the previous read in one of the four strand orientations. It runs
// under three idling mixes and several mismatch rates, including 0, 1000 and
// 1023.
// ----------------------------------------------------------------------------
module tb_read_overlap_orientation_finder;
   import roof_pkg::*;

   localparam int SETTLE_CYCLES = 10;       // quiet cycles before a register write
   localparam int DRAIN_LIMIT   = 200000;   // bound on the final drain, in cycles
   localparam int RUN_LIMIT_NS  = 10000000; // hard stop for a hung run
   localparam int SEG_BEATS     = 60;       // random beats per register setting
   localparam int PERMILLE_PICK = -1;       // plan entry: draw a random rate
   localparam int SEND_GAP [3]      = '{31, 63, 0};
   localparam int RECV_GAP [3]      = '{63, 31, 0};
   localparam int PERMILLE_PLAN [6] = '{0, 1000, 1023, 50, PERMILLE_PICK, 200};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [PERMILLE_W-1:0] csr_write_data = '0;

   read_overlap_orientation_finder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the block state: two banks, lengths, and the active rate.
   logic [7:0]            read_bank [2][MAX_LEN];
   int unsigned           prev_len = 0;
   int unsigned           cur_len = 0;
   bit                    prev_ok = 1'b0;
   bit                    cur_bank = 1'b0;
   bit                    over_flag = 1'b0;
   logic [PERMILLE_W-1:0] permille_now = PERMILLE_RESET;

   // Beats waiting to be sent, and verdicts waiting for their response beat.
   req_payload_type       beat_queue [$];
   rsp_payload_type       verdicts_due [$];

   // Generator scratch: the read under construction and the last read queued.
   logic [7:0]            read_buf [$];
   logic [7:0]            last_read [$];

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int beats_planned = 0;
   int beats_accepted = 0;
   int reads_checked = 0;
   int truncated_reads = 0;
   int error_count = 0;
   int orient_tally [5] = '{0, 0, 0, 0, 0};

   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic logic [7:0] strand_complement(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      unique case (c)
         "A": r = "T";
         "T": r = "A";
         "C": r = "G";
         "G": r = "C";
         "a": r = "t";
         "t": r = "a";
         "c": r = "g";
         "g": r = "c";
         default: r = c;
      endcase
      return r;
   endfunction

   // Take one accepted base. On a closing beat, score the read against the
   // previous one and queue the verdict, then swap the banks.
   task automatic track_base(input req_payload_type beat);
      rsp_payload_type verdict;
      int unsigned ol, bound, ff, fr, rf, rr, pos;
      logic [7:0]  f1, r1, f2, r2;
      bit          pb;
      if (cur_len < MAX_LEN) begin
         read_bank[cur_bank][cur_len] = beat.base_char;
         cur_len++;
      end else begin
         over_flag = 1'b1;
      end
      if (!beat.last_base) return;

      pb = ~cur_bank;
      verdict.orientation   = ORIENT_NONE;
      verdict.overlap_shift = SHIFT_NONE;
      verdict.truncated     = over_flag;
      if (prev_ok) begin
         // Walk the shifts in order; the first shift with any orientation
         // inside the bound wins, FF before FR before RF before RR.
         for (int unsigned d = 0; d < prev_len / 2 && verdict.orientation == ORIENT_NONE;
              d++) begin
            ol    = (prev_len - d < cur_len) ? prev_len - d : cur_len;
            bound = (ol * permille_now + 499) / 1000;
            ff = 0; fr = 0; rf = 0; rr = 0;
            for (int unsigned j = 0; j < ol; j++) begin
               pos = d + j;
               f1  = read_bank[pb][pos];
               r1  = strand_complement(read_bank[pb][prev_len - 1 - pos]);
               f2  = read_bank[cur_bank][j];
               r2  = strand_complement(read_bank[cur_bank][cur_len - 1 - j]);
               ff += (f1 != f2);
               fr += (f1 != r2);
               rf += (r1 != f2);
               rr += (r1 != r2);
            end
            if (ff <= bound)      verdict.orientation = ORIENT_FF;
            else if (fr <= bound) verdict.orientation = ORIENT_FR;
            else if (rf <= bound) verdict.orientation = ORIENT_RF;
            else if (rr <= bound) verdict.orientation = ORIENT_RR;
            if (verdict.orientation != ORIENT_NONE) verdict.overlap_shift = 8'(d);
         end
      end
      verdicts_due.push_back(verdict);

      prev_len  = cur_len;
      prev_ok   = 1'b1;
      cur_bank  = pb;
      cur_len   = 0;
      over_flag = 1'b0;
   endtask

   // Driver: advance to the next pending beat once the current one is taken;
   // hold the payload steady while stalled.
   always @(posedge clock) begin : drive_bases
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_base(req_data);
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (beat_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_data  <= beat_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every response beat against the oldest verdict, and
   // throttle the response side at random.
   always @(posedge clock) begin : check_verdicts
      rsp_payload_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (verdicts_due.size() == 0) begin
               flag_error($sformatf("response beat with no closed read: orient %0d shift %0d",
                                    got.orientation, got.overlap_shift));
            end else begin
               want = verdicts_due.pop_front();
               if (got.orientation !== want.orientation)
                  flag_error($sformatf("read %0d: orientation %0d, expected %0d",
                                       reads_checked, got.orientation, want.orientation));
               if (got.overlap_shift !== want.overlap_shift)
                  flag_error($sformatf("read %0d: shift %0d, expected %0d",
                                       reads_checked, got.overlap_shift,
                                       want.overlap_shift));
               if (got.truncated !== want.truncated)
                  flag_error($sformatf("read %0d: truncated %0b, expected %0b",
                                       reads_checked, got.truncated, want.truncated));
               orient_tally[want.orientation]++;
               if (want.truncated) truncated_reads++;
               reads_checked++;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_gap_pct);
      end
   end

   // ---- stimulus helpers ----

   function automatic logic [7:0] pick_base(input bit lower);
      logic [7:0] up;
      case ($urandom_range(0, 3))
         0:       up = CHAR_A_UP;
         1:       up = CHAR_C_UP;
         2:       up = CHAR_G_UP;
         default: up = CHAR_T_UP;
      endcase
      return lower ? (up | 8'h20) : up;
   endfunction

   function automatic int pick_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
   endfunction

   task automatic flip_strand(ref logic [7:0] seq [$]);
      logic [7:0] fwd [$];
      fwd = seq;
      seq.delete();
      for (int k = fwd.size() - 1; k >= 0; k--) seq.push_back(strand_complement(fwd[k]));
   endtask

   // Move the read under construction into the beat queue, last beat marked.
   task automatic enqueue_read();
      req_payload_type beat;
      last_read.delete();
      foreach (read_buf[k]) begin
         beat.base_char = read_buf[k];
         beat.last_base = (k == read_buf.size() - 1);
         beat_queue.push_back(beat);
         if (k < MAX_LEN) last_read.push_back(read_buf[k]);
      end
      beats_planned += read_buf.size();
   endtask

   task automatic queue_text(input string text);
      read_buf.delete();
      for (int k = 0; k < text.len(); k++) read_buf.push_back(text[k]);
      enqueue_read();
   endtask

   // lower_pct: chance per base of a lowercase letter.
   task automatic build_plain_read(input int n, input int lower_pct);
      read_buf.delete();
      for (int k = 0; k < n; k++)
         read_buf.push_back(pick_base($urandom_range(0, 99) < lower_pct));
   endtask

   task automatic build_noise_read(input int n);
      read_buf.delete();
      for (int k = 0; k < n; k++) read_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // Cut a read out of the last one at a random shift, in a random strand
   // orientation, with a random tail and a few point mutations.
   task automatic build_overlap_read();
      logic [7:0] src [$];
      orient_type o;
      int         d, keep, tail, flips, span;
      src = last_read;
      o   = orient_type'($urandom_range(1, 4));
      if (o == ORIENT_RF || o == ORIENT_RR) flip_strand(src);
      d     = $urandom_range(0, src.size() / 2 - 1);
      span  = (src.size() - d > 48) ? 48 : src.size() - d;
      keep  = $urandom_range(1, span);
      tail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      flips = $urandom_range(0, 2);
      read_buf.delete();
      for (int k = 0; k < keep; k++) read_buf.push_back(src[d + k]);
      for (int k = 0; k < tail; k++) read_buf.push_back(pick_base(1'b0));
      for (int k = 0; k < flips; k++)
         read_buf[$urandom_range(0, read_buf.size() - 1)] = pick_base(1'b0);
      if (o == ORIENT_FR || o == ORIENT_RR) flip_strand(read_buf);
   endtask

   task automatic build_next_read();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60 && last_read.size() >= 2)
         build_overlap_read();
      else if (roll < 75)
         build_plain_read(pick_length(), 5);
      else if (roll < 88)
         build_plain_read(pick_length(), 100);
      else
         build_noise_read(pick_length());
   endtask

   // Hold until every queued beat is taken and every verdict has come back,
   // then let the block settle.
   task automatic wait_quiet();
      while (beats_accepted != beats_planned || verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_permille(input logic [PERMILLE_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      permille_now = value;
   endtask

   // ---- main sequence ----
   initial begin : stimulus
      int rate, n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = SEND_GAP[0];
      recv_gap_pct = RECV_GAP[0];

      // Directed reads at the reset rate. The first read has nothing before
      // it. The second is its reverse complement. A one-base read follows,
      // and the read after it sees a predecessor too short to shift. Then
      // come odd bytes and lowercase bases.
      queue_text("ACGTTG");
      queue_text("CAACGT");
      queue_text("A");
      queue_text("ACG");
      read_buf = '{8'h00, 8'hFF, 8'h80, CHAR_A_LO, CHAR_T_LO, CHAR_G_LO, CHAR_C_LO};
      enqueue_read();
      queue_text("tgc");

      for (int m = 0; m < 3; m++) begin
         send_gap_pct = SEND_GAP[m];
         recv_gap_pct = RECV_GAP[m];
         for (int s = 0; s < 2; s++) begin
            wait_quiet();
            rate = PERMILLE_PLAN[2 * m + s];
            if (rate == PERMILLE_PICK) rate = $urandom_range(0, 1023);
            write_permille(PERMILLE_W'(rate));
            // Open the first segment with an overlong read so that the extra
            // bases are dropped and flagged.
            if (s == 0 && m == 0) begin
               build_plain_read(MAX_LEN + $urandom_range(1, 16), 5);
               enqueue_read();
            end
            n = beats_planned + SEG_BEATS;
            while (beats_planned < n) begin
               build_next_read();
               enqueue_read();
            end
         end
      end

      // Drain with a bound, then flag anything that never came back.
      n = 0;
      while ((beats_accepted != beats_planned || verdicts_due.size() != 0) && n < DRAIN_LIMIT)
      begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (verdicts_due.size() != 0)
         flag_error($sformatf("%0d verdicts never answered", verdicts_due.size()));

      $display("Summary: %0d bases in %0d reads checked, %0d of them truncated",
               beats_accepted, reads_checked, truncated_reads);
      $display("Summary: none %0d, FF %0d, FR %0d, RF %0d, RR %0d; %0d errors",
               orient_tally[0], orient_tally[1], orient_tally[2], orient_tally[3],
               orient_tally[4], error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timeout: %0d of %0d bases taken, %0d verdicts pending",
               beats_accepted, beats_planned, verdicts_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== read_overlap_orientation_finder.f =====
rtl/roof_pkg.sv
rtl/roof_dp.sv
rtl/roof_ctrl.sv
rtl/read_overlap_orientation_finder.sv
rtl/roof_chk.sv
tb/tb_read_overlap_orientation_finder.sv
